/* rtl/assert_macros.svh */
// Assertion macros for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression on every clock edge outside reset.
`define RLMS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define RLMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rlms_pkg.sv */
// Shared types, constants and defaults of the LED matrix row scanner.
package rlms_pkg;

    localparam int ROWS_DEF          = 8;
    localparam int BYTES_PER_ROW_DEF = 24;
    localparam int BANK0_BYTES_DEF   = 18;

    localparam int HOLD_W = 16;
    localparam int GAP_W  = 8;
    localparam int CFG_W  = 16;

    localparam logic [HOLD_W-1:0] RESET_HOLD_DEF = 16'd1000;
    localparam logic [GAP_W-1:0]  LATCH_GAP_DEF  = 8'd4;

    // Configuration register indexes
    localparam logic CFG_RESET_HOLD = 1'b0;
    localparam logic CFG_LATCH_GAP  = 1'b1;

    // Input item kinds carried on tuser
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef enum logic [2:0] {
        PH_HOLD,
        PH_BANK0,
        PH_BANK0_LATCH,
        PH_SHIFT,
        PH_GAP
    } rlms_phase_t;

    // Pin levels of one tick, before the frame byte bit is merged in
    typedef struct packed {
        logic       reset_pin;
        logic       bank_select;
        logic       sd_one;
        logic       sd_from_mem;
        logic       clock_pulse;
        logic       latch_pulse;
        logic [7:0] row_enable;
        logic [2:0] bit_sel;
    } rlms_pins_t;

endpackage

/* rtl/rlms_frame_mem.sv */
// Frame byte store with per-entry valid bits and a registered read port.
module rlms_frame_mem #(
    parameter int DEPTH  = 192,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data,
    output logic              rd_valid
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Entries never written since reset read with rd_valid low
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

/* rtl/rlms_seq.sv */
// Tick sequencer: reset hold, bank 0 load, then the endless row scan.
module rlms_seq #(
    parameter int ROWS          = 8,
    parameter int BYTES_PER_ROW = 24,
    parameter int BANK0_BYTES   = 18,
    parameter int ADDR_W        = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [rlms_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        step,
    output rlms_pkg::rlms_pins_t        pins,
    output logic [ADDR_W-1:0]           rd_addr
);
    import rlms_pkg::*;

    localparam int MAXB   = (BYTES_PER_ROW > BANK0_BYTES) ? BYTES_PER_ROW : BANK0_BYTES;
    localparam int BYTE_W = $clog2(MAXB);
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [BYTE_W-1:0] ROW_LAST_BYTE   = BYTE_W'(BYTES_PER_ROW - 1);
    localparam logic [BYTE_W-1:0] BANK0_LAST_BYTE = BYTE_W'(BANK0_BYTES - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW        = ROW_W'(ROWS - 1);

    rlms_phase_t       phase_reg, phase_next;
    logic [2:0]        bit_reg, bit_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [HOLD_W-1:0] wait_reg, wait_next;
    logic [7:0]        drive_reg, drive_next;
    logic [HOLD_W-1:0] hold_ticks_reg;
    logic [GAP_W-1:0]  gap_ticks_reg;

    logic [2:0]        adv_bit;
    logic [BYTE_W-1:0] adv_byte;
    logic              adv_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_ticks_reg <= RESET_HOLD_DEF;
            gap_ticks_reg  <= LATCH_GAP_DEF;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RESET_HOLD: hold_ticks_reg <= cfg_data;
                CFG_LATCH_GAP:  gap_ticks_reg  <= cfg_data[GAP_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HOLD;
            bit_reg   <= 3'd7;
            byte_reg  <= ROW_LAST_BYTE;
            row_reg   <= '0;
            wait_reg  <= '0;
            drive_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            row_reg   <= row_next;
            wait_reg  <= wait_next;
            drive_reg <= drive_next;
        end
    end

    // Step down one bit, MSB first; done once bit 0 of byte 0 went out
    always_comb begin
        adv_bit  = bit_reg;
        adv_byte = byte_reg;
        adv_done = 1'b0;
        if (bit_reg != 3'd0) begin
            adv_bit = bit_reg - 3'd1;
        end else begin
            adv_bit = 3'd7;
            if (byte_reg != '0) begin
                adv_byte = byte_reg - BYTE_W'(1);
            end else begin
                adv_done = 1'b1;
            end
        end
    end

    assign rd_addr = ADDR_W'(int'(row_reg) * BYTES_PER_ROW + int'(byte_reg));

    always_comb begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        row_next   = row_reg;
        wait_next  = wait_reg;
        drive_next = drive_reg;
        pins       = '{reset_pin: 1'b1, bank_select: 1'b1, sd_one: 1'b0,
                       sd_from_mem: 1'b0, clock_pulse: 1'b0, latch_pulse: 1'b0,
                       row_enable: 8'd0, bit_sel: bit_reg};
        case (phase_reg)
            PH_HOLD: begin
                if (wait_reg < hold_ticks_reg) begin
                    wait_next         = wait_reg + HOLD_W'(1);
                    pins.reset_pin    = 1'b0;
                end else begin
                    // First bank 0 bit goes out on this tick already
                    phase_next        = PH_BANK0;
                    byte_next         = BANK0_LAST_BYTE;
                    bit_next          = 3'd6;
                    wait_next         = '0;
                    pins.bank_select  = 1'b0;
                    pins.sd_one       = 1'b1;
                    pins.clock_pulse  = 1'b1;
                end
            end
            PH_BANK0: begin
                bit_next         = adv_bit;
                byte_next        = adv_byte;
                if (adv_done) begin
                    phase_next = PH_BANK0_LATCH;
                end
                pins.bank_select = 1'b0;
                pins.sd_one      = 1'b1;
                pins.clock_pulse = 1'b1;
            end
            PH_BANK0_LATCH: begin
                phase_next       = PH_SHIFT;
                byte_next        = ROW_LAST_BYTE;
                bit_next         = 3'd7;
                row_next         = '0;
                pins.bank_select = 1'b0;
                pins.latch_pulse = 1'b1;
            end
            PH_SHIFT: begin
                pins.sd_from_mem = 1'b1;
                pins.clock_pulse = 1'b1;
                pins.row_enable  = drive_reg;
                bit_next         = adv_bit;
                byte_next        = adv_byte;
                if (adv_done) begin
                    phase_next = PH_GAP;
                    wait_next  = '0;
                end
            end
            PH_GAP: begin
                drive_next = '0;
                if (wait_reg < HOLD_W'(gap_ticks_reg)) begin
                    wait_next = wait_reg + HOLD_W'(1);
                end else begin
                    // Latch, then enable the row just shifted
                    pins.latch_pulse = 1'b1;
                    drive_next       = 8'd1 << row_reg;
                    row_next         = (row_reg == LAST_ROW) ? '0 : row_reg + ROW_W'(1);
                    phase_next       = PH_SHIFT;
                    byte_next        = ROW_LAST_BYTE;
                    bit_next         = 3'd7;
                    wait_next        = '0;
                end
            end
            default: begin
                phase_next = PH_HOLD;
            end
        endcase
    end

endmodule

/* rtl/rgb_led_matrix_row_scanner.sv */
// Top level of the RGB LED matrix row scanner: item stages, sequencer, frame store.
//
//  channel  | dir | accepted when            | payload
//  ---------+-----+--------------------------+-------------------------------------------
//  s_       | in  | s_tvalid && s_tready     | tuser = kind (tick/write), tdata = addr, data
//  m_       | out | m_tvalid && m_tready     | tdata = pin levels of one tick
//  cfg_     | in  | cfg_wr_en                | cfg_index selects hold or gap tick count
//
// One item per clock while the result side does not stall. An item sits in the input
// register, where the sequencer and the frame store port act on it; a tick then moves
// to the result register, with the frame store read data landing beside it.
// Writes give no result. The input side keeps accepting while a result waits,
// stalling only when both registers hold a tick. Reset is synchronous, active low,
// and clears the frame store at once through its valid bits.
`include "assert_macros.svh"

module rgb_led_matrix_row_scanner #(
    parameter int ROWS          = rlms_pkg::ROWS_DEF,
    parameter int BYTES_PER_ROW = rlms_pkg::BYTES_PER_ROW_DEF,
    parameter int BANK0_BYTES   = rlms_pkg::BANK0_BYTES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [7:0] address, [15:8] data
    input  logic [0:0]                  s_tuser,   // [0] action
    // Result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [0] reset_pin, [1] bank_select,
                                                   // [2] serial_data, [3] clock_pulse,
                                                   // [4] latch_pulse, [12:5] row_enable,
                                                   // [15:13] zero
    // Configuration writes
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [rlms_pkg::CFG_W-1:0]  cfg_data
);
    import rlms_pkg::*;

    localparam int FRAME_BYTES = ROWS * BYTES_PER_ROW;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);

    // Input register
    logic       a_valid_reg, a_valid_next;
    logic       a_action_reg;
    logic [7:0] a_addr_reg;
    logic [7:0] a_data_reg;

    // Result register
    logic       b_valid_reg, b_valid_next;
    rlms_pins_t b_pins_reg;

    logic              s_accept;
    logic              a_advance;
    logic              b_load;
    logic              mem_wr_en;
    rlms_pins_t        seq_pins;
    logic [ADDR_W-1:0] seq_rd_addr;
    logic [7:0]        mem_rd_data;
    logic              mem_rd_valid;
    logic              serial_data;

    // Move the item on unless a tick finds the result register still full
    assign a_advance = a_valid_reg && ((a_action_reg == ACT_WRITE) || !b_valid_reg || m_tready);
    assign s_tready  = !a_valid_reg || a_advance;
    assign s_accept  = s_tvalid && s_tready;
    assign b_load    = a_advance && (a_action_reg == ACT_TICK);

    // Drop writes beyond the frame
    assign mem_wr_en = a_advance && (a_action_reg == ACT_WRITE)
                       && (int'(a_addr_reg) < FRAME_BYTES);

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_accept) begin
            a_valid_next = 1'b1;
        end else if (a_advance) begin
            a_valid_next = 1'b0;
        end
    end

    always_comb begin
        b_valid_next = b_valid_reg;
        if (b_load) begin
            b_valid_next = 1'b1;
        end else if (m_tready) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Payload registers: capture on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_action_reg <= s_tuser[0];
            a_addr_reg   <= s_tdata[7:0];
            a_data_reg   <= s_tdata[15:8];
        end
        if (b_load) begin
            b_pins_reg <= seq_pins;
        end
    end

    rlms_seq #(
        .ROWS          (ROWS),
        .BYTES_PER_ROW (BYTES_PER_ROW),
        .BANK0_BYTES   (BANK0_BYTES),
        .ADDR_W        (ADDR_W)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (b_load),
        .pins      (seq_pins),
        .rd_addr   (seq_rd_addr)
    );

    // Read the byte for the tick entering the result register; items pass in
    // order, so an earlier write has already landed
    rlms_frame_mem #(
        .DEPTH  (FRAME_BYTES),
        .ADDR_W (ADDR_W)
    ) u_frame_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (mem_wr_en),
        .wr_addr  (ADDR_W'(a_addr_reg)),
        .wr_data  (a_data_reg),
        .rd_en    (b_load),
        .rd_addr  (seq_rd_addr),
        .rd_data  (mem_rd_data),
        .rd_valid (mem_rd_valid)
    );

    // Merge the frame bit into the registered pin levels
    assign serial_data = b_pins_reg.sd_one
                         || (b_pins_reg.sd_from_mem && mem_rd_valid
                             && mem_rd_data[b_pins_reg.bit_sel]);

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = {3'b000,
                       b_pins_reg.row_enable,
                       b_pins_reg.latch_pulse,
                       b_pins_reg.clock_pulse,
                       serial_data,
                       b_pins_reg.bank_select,
                       b_pins_reg.reset_pin};

    // Checks
    `RLMS_ASSERT_ALWAYS(a_rows_onehot, !b_valid_reg || $onehot0(b_pins_reg.row_enable), "more than one row enabled")
    `RLMS_ASSERT_ALWAYS(a_latch_no_clk, !b_valid_reg || !(b_pins_reg.latch_pulse && b_pins_reg.clock_pulse), "latch and clock pulse on one tick")
    `RLMS_ASSERT_ALWAYS(a_ready_when_empty, b_valid_reg || s_tready, "input stalled with empty result register")
    `RLMS_ASSERT_NEXT(a_write_no_result, a_valid_reg && (a_action_reg == ACT_WRITE) && !b_valid_reg, !b_valid_reg, "write item produced a result")

endmodule

/* test/tb_rgb_led_matrix_row_scanner.sv */
// Self-checking testbench of the LED matrix row scanner: frame writes and ticks against a scan model.
module tb_rgb_led_matrix_row_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    import rlms_pkg::*;

    localparam int FRAME_BYTES   = ROWS_DEF * BYTES_PER_ROW_DEF;
    localparam int SETTLE_CYCLES = 6;

    // Pin levels of one tick, packed in the order of m_tdata, reset_pin at bit 0
    typedef struct packed {
        logic [7:0] row_enable;
        logic       latch_pulse;
        logic       clock_pulse;
        logic       serial_data;
        logic       bank_select;
        logic       reset_pin;
    } scan_pins_t;

    typedef struct {
        logic       action;
        logic [7:0] address;
        logic [7:0] value;
    } scan_item_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata   = '0;        // [7:0] address, [15:8] data
    logic [0:0]          s_tuser   = ACT_TICK;  // [0] action
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [15:0]         m_tdata;               // [0] reset_pin, [1] bank_select,
                                                // [2] serial_data, [3] clock_pulse,
                                                // [4] latch_pulse, [12:5] row_enable
    logic                cfg_wr_en = 1'b0;
    logic                cfg_index = CFG_RESET_HOLD;
    logic [CFG_W-1:0]    cfg_data  = '0;

    scan_item_t item_q[$];   // items waiting for the driver
    scan_pins_t pins_q[$];   // pin levels still to come out, oldest first
    int         mismatches = 0;

    // Scan model state and its copy of the registers
    logic [7:0]        frame_mem [FRAME_BYTES];
    rlms_phase_t       scan_phase;
    logic [2:0]        shift_bit;
    logic [4:0]        shift_byte;
    logic [2:0]        scan_row;
    logic [15:0]       tick_wait;
    logic [7:0]        row_drive;
    logic [HOLD_W-1:0] hold_ticks;
    logic [GAP_W-1:0]  gap_ticks;

    always #1 aclk = ~aclk;

    rgb_led_matrix_row_scanner i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Step the bit and byte counters of the serializer; return 1 once the last bit is out.
    function automatic bit step_bit_counters();
        if (shift_bit != 3'd0) begin
            shift_bit--;
            return 1'b0;
        end
        shift_bit = 3'd7;
        if (shift_byte != 5'd0) begin
            shift_byte--;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one item to the scan model; a tick returns 1 with the pins it produces.
    function automatic bit scan_step(input logic action, input logic [7:0] address,
                                     input logic [7:0] value, output scan_pins_t pins);
        logic [7:0] frame_byte;
        pins = '0;
        if (action == ACT_WRITE) begin
            // Drop writes past the end of the frame store
            if (address < FRAME_BYTES) begin
                frame_mem[address] = value;
            end
            return 1'b0;
        end
        if (scan_phase == PH_HOLD) begin
            if (tick_wait < hold_ticks) begin
                tick_wait++;
                pins.bank_select = 1'b1;
                return 1'b1;
            end
            // Hold over: the same tick already shifts the first bank 0 bit
            scan_phase = PH_BANK0;
            shift_byte = 5'(BANK0_BYTES_DEF - 1);
            shift_bit  = 3'd7;
            tick_wait  = '0;
        end
        if (scan_phase == PH_BANK0) begin
            if (step_bit_counters()) begin
                scan_phase = PH_BANK0_LATCH;
            end
            pins.reset_pin   = 1'b1;
            pins.serial_data = 1'b1;
            pins.clock_pulse = 1'b1;
            return 1'b1;
        end
        if (scan_phase == PH_BANK0_LATCH) begin
            scan_phase = PH_SHIFT;
            shift_byte = 5'(BYTES_PER_ROW_DEF - 1);
            shift_bit  = 3'd7;
            scan_row   = '0;
            pins.reset_pin   = 1'b1;
            pins.latch_pulse = 1'b1;
            return 1'b1;
        end
        pins.reset_pin   = 1'b1;
        pins.bank_select = 1'b1;
        if (scan_phase == PH_SHIFT) begin
            // The row enabled last stays on while the next one shifts in
            frame_byte = frame_mem[scan_row * BYTES_PER_ROW_DEF + shift_byte];
            pins.serial_data = frame_byte[shift_bit];
            pins.clock_pulse = 1'b1;
            pins.row_enable  = row_drive;
            if (step_bit_counters()) begin
                scan_phase = PH_GAP;
                tick_wait  = '0;
            end
            return 1'b1;
        end
        // Gap with all rows off; the tick that ends it pulses the latch
        row_drive = '0;
        if (tick_wait < gap_ticks) begin
            tick_wait++;
            return 1'b1;
        end
        pins.latch_pulse = 1'b1;
        row_drive  = 8'b1 << scan_row;
        scan_row++;
        scan_phase = PH_SHIFT;
        shift_byte = 5'(BYTES_PER_ROW_DEF - 1);
        shift_bit  = 3'd7;
        tick_wait  = '0;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void add_item(input logic action, input logic [7:0] address,
                                     input logic [7:0] value);
        item_q.push_back('{action, address, value});
    endfunction

    // Write one register while the block is idle and mirror it in the model.
    task automatic set_reg(input logic index, input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (index == CFG_RESET_HOLD) begin
            hold_ticks = value;
        end else begin
            gap_ticks = value[GAP_W-1:0];
        end
        @(negedge aclk);
    endtask

    // Hold until every item is sent and every expected result is back, then let
    // trailing writes leave the two-stage pipeline.
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (item_q.size() != 0 || s_tvalid || pins_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // Driver: present queued items, run the model on each accepted one, and
    // hold off a random number of cycles after each item, with idle-free bursts.
    int feed_gap   = 0;
    bit feed_burst = 1'b0;

    always @(posedge aclk) begin : feed
        scan_item_t next_item;
        scan_pins_t tick_pins;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (scan_step(s_tuser[0], s_tdata[7:0], s_tdata[15:8], tick_pins)) begin
                    pins_q.push_back(tick_pins);
                end
            end
            if (!s_tvalid || s_tready) begin
                if (feed_gap > 0) begin
                    s_tvalid <= 1'b0;
                    feed_gap--;
                end else if (item_q.size() != 0) begin
                    next_item = item_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_item.action;
                    s_tdata  <= {next_item.value, next_item.address};
                    if ($urandom_range(0, 49) == 0) begin
                        feed_burst = !feed_burst;
                    end
                    feed_gap = feed_burst ? 0 : $urandom_range(0, 6);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation, then
    // stall the result side for a random number of cycles.
    int drain_stall = 0;
    bit drain_burst = 1'b0;

    always @(posedge aclk) begin : watch
        scan_pins_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pins_q.size() == 0) begin
                    $error("result item with nothing expected: tdata %h", m_tdata);
                    mismatches++;
                end else begin
                    want = pins_q.pop_front();
                    check_field("reset_pin",   want.reset_pin,   m_tdata[0]);
                    check_field("bank_select", want.bank_select, m_tdata[1]);
                    check_field("serial_data", want.serial_data, m_tdata[2]);
                    check_field("clock_pulse", want.clock_pulse, m_tdata[3]);
                    check_field("latch_pulse", want.latch_pulse, m_tdata[4]);
                    check_field("row_enable",  want.row_enable,  m_tdata[12:5]);
                    check_field("padding",     8'd0,             m_tdata[15:13]);
                end
                if ($urandom_range(0, 49) == 0) begin
                    drain_burst = !drain_burst;
                end
                drain_stall = drain_burst ? 0 : $urandom_range(0, 6);
            end
            if (drain_stall > 0) begin
                m_tready <= 1'b0;
                drain_stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus: directed items first, then random phases under several gap settings.
    initial begin : stimulus
        int          phase_items [4];
        logic [15:0] phase_gap [4];
        phase_items = '{600, 520, 340, 420};
        // Sized so the 255-tick gap phase can span one whole row plus its gap
        phase_gap   = '{16'd0, 16'd255, 16'($urandom_range(1, 32)), 16'd1};

        foreach (frame_mem[i]) begin
            frame_mem[i] = '0;
        end
        scan_phase = PH_HOLD;
        shift_bit  = 3'd7;
        shift_byte = 5'(BYTES_PER_ROW_DEF - 1);
        scan_row   = '0;
        tick_wait  = '0;
        row_drive  = '0;
        hold_ticks = RESET_HOLD_DEF;
        gap_ticks  = LATCH_GAP_DEF;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Longest reset hold, shortest gap
        set_reg(CFG_RESET_HOLD, 16'hFFFF);
        set_reg(CFG_LATCH_GAP, phase_gap[0]);

        // Frame writes at the ends of the store and of rows, plus two past the end
        add_item(ACT_WRITE, 8'd0,   8'hFF);
        add_item(ACT_WRITE, 8'd191, 8'h80);
        add_item(ACT_WRITE, 8'd23,  8'h01);
        add_item(ACT_WRITE, 8'd24,  8'hAA);
        add_item(ACT_WRITE, 8'd47,  8'h7F);
        add_item(ACT_WRITE, 8'd168, 8'h55);
        add_item(ACT_WRITE, 8'd192, 8'hFF);
        add_item(ACT_WRITE, 8'd255, 8'h00);
        // Ticks inside the reset hold
        repeat (3) add_item(ACT_TICK, 8'hFF, 8'hFF);
        repeat (3) add_item(ACT_TICK, 8'h00, 8'h00);
        wait_idle();

        // Zero hold: the next tick leaves the hold and shifts the first bank 0 bit
        set_reg(CFG_RESET_HOLD, 16'd0);
        repeat (6) add_item(ACT_TICK, 8'h5A, 8'hA5);

        for (int p = 0; p < 4; p++) begin
            if (p > 0) begin
                wait_idle();
                set_reg(CFG_LATCH_GAP, phase_gap[p]);
                set_reg(CFG_RESET_HOLD, 16'($urandom));
            end
            for (int n = 0; n < phase_items[p]; n++) begin
                if ($urandom_range(0, 99) < 91) begin
                    add_item(ACT_TICK, 8'($urandom), 8'($urandom));
                end else if ($urandom_range(0, 15) == 0) begin
                    add_item(ACT_WRITE, 8'($urandom_range(FRAME_BYTES, 255)), 8'($urandom));
                end else begin
                    add_item(ACT_WRITE, 8'($urandom_range(0, FRAME_BYTES - 1)), 8'($urandom));
                end
            end
        end

        // Drain, then watch a few more cycles for stray results
        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && pins_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #500000;
        $display("simulation failed");
        $finish;
    end

endmodule
